// ----- rtl/pbr_pkg.sv -----
// ----------------------------------------------------------------------------
// pbr_pkg
// shared types and codes of the planar byterun1 decoder
// ----------------------------------------------------------------------------
package pbr_pkg;

    // decoder phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_REPEAT,
        PH_DONE,
        PH_ERROR
    } pbr_phase_t;

    // decode status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERRUN   = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;

    // configuration register indexes
    localparam logic [7:0] REG_COMPRESSION_MODE = 8'd0;
    localparam logic [7:0] REG_IMAGE_WIDTH      = 8'd1;
    localparam logic [7:0] REG_IMAGE_ROWS       = 8'd2;
    localparam logic [7:0] REG_PLANE_COUNT      = 8'd3;

    // packbits no-op header (-128) and rounding to 16-pixel words
    localparam logic [7:0]  HDR_NOP    = 8'h80;
    localparam logic [12:0] WORD_ROUND = 13'd15;

    // result word packing
    localparam int TDATA_W = 40;
    localparam int TUSER_W = 3;

    typedef struct packed {
        logic        mode;
        logic [11:0] width;
        logic [10:0] rows;
        logic [3:0]  planes;
    } pbr_cfg_t;

    typedef struct packed {
        logic       run_valid;
        logic [7:0] run_value;
        logic [7:0] run_length;
        logic [2:0] plane_index;
        logic [9:0] row_index;
        logic [7:0] byte_offset;
        logic [1:0] decode_status;
        logic       image_done;
    } pbr_run_t;

endpackage

// ----- rtl/planar_byterun1_decoder.sv -----
// ----------------------------------------------------------------------------
// planar_byterun1_decoder
// packbits / raw body decoder for interleaved planar images
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock and turns it into run words for
// a planar writer: literal bytes come out as runs of length one, a repeat
// header and its byte come out as one run with its length, and each run is
// tagged with plane, row and byte offset inside the plane row. Headers and
// no-op bytes make no word. A run past the row end gives a status word and
// stops decoding; a last byte before the image is full gives the early-end
// status. After an error or a finished image, bytes are dropped until the
// last-byte marker, which always rearms the decoder. Throughput is one byte
// per cycle while the queue has room; an accepted byte's word is written to
// the queue and then loaded into the output register. The front tracks phase
// and position in one registered loop, and a four-entry queue plus the output
// register let either side stall, so s_tready falls only while the queue is
// full. Configuration must be written on the cfg channel only while no body
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module planar_byterun1_decoder #(
    parameter int MAX_ROW_BYTES = 256,
    parameter int MAX_PLANES    = 8,
    parameter int MAX_ROWS      = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   cfg_index,
    input  logic [11:0]                  cfg_data,
    // body byte stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // body_byte
    input  logic                         s_tlast,   // body_last
    // run word stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // run_value[7:0], run_length[15:8], plane_index[18:16],
    // row_index[28:19], byte_offset[36:29], zero pad[39:37]
    output logic [pbr_pkg::TDATA_W-1:0]  m_tdata,
    // run_valid[0], decode_status[2:1]
    output logic [pbr_pkg::TUSER_W-1:0]  m_tuser,
    output logic                         m_tlast    // image_done
);

    // configuration registers, always ready
    logic        mode_reg;
    logic [11:0] width_reg;
    logic [10:0] rows_reg;
    logic [3:0]  planes_reg;
    logic        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b1;
            width_reg  <= 12'd320;
            rows_reg   <= 11'd256;
            planes_reg <= 4'd5;
        end else if (cfg_fire) begin
            case (cfg_index)
                pbr_pkg::REG_COMPRESSION_MODE: mode_reg   <= cfg_data[0];
                pbr_pkg::REG_IMAGE_WIDTH:      width_reg  <= cfg_data;
                pbr_pkg::REG_IMAGE_ROWS:       rows_reg   <= cfg_data[10:0];
                pbr_pkg::REG_PLANE_COUNT:      planes_reg <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    pbr_pkg::pbr_cfg_t cfg;
    assign cfg.mode   = mode_reg;
    assign cfg.width  = width_reg;
    assign cfg.rows   = rows_reg;
    assign cfg.planes = planes_reg;

    // front: classify bytes, track position
    logic              s_fire, q_full, q_push, q_pop, q_nonempty;
    pbr_pkg::pbr_run_t front_run, q_run;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;

    pbr_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_PLANES    (MAX_PLANES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_fire  (s_fire),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .out_push (q_push),
        .out_run  (front_run)
    );

    // queue decouples the byte side from the writer side
    pbr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .din      (front_run),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .dout     (q_run)
    );

    // back: output register and word packing
    pbr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (q_nonempty),
        .q_run      (q_run),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // image completion is only ever reported on a run
    a_done_on_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("image done without a run");

    // a word without a run always carries a status
    a_empty_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tuser[2:1] != pbr_pkg::ST_OK))
        else $error("empty word with ok status");

    // an overrun never comes with run data
    a_overrun_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] == pbr_pkg::ST_OVERRUN) |-> !m_tuser[0])
        else $error("overrun word carries a run");

    // no word straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("word present after reset");

endmodule

// ----- rtl/pbr_front.sv -----
// ----------------------------------------------------------------------------
// pbr_front
// byte classifier and position tracker: turns body bytes into run words
// ----------------------------------------------------------------------------
module pbr_front #(
    parameter int MAX_ROW_BYTES = 256,
    parameter int MAX_PLANES    = 8,
    parameter int MAX_ROWS      = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pbr_pkg::pbr_cfg_t cfg,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              out_push,
    output pbr_pkg::pbr_run_t out_run
);

    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int SUM_A  = $clog2(MAX_ROW_BYTES + 128) + 1;
    localparam int SUM_W  = (SUM_A > 10) ? SUM_A : 10;
    localparam int PL_W   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int RW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RC_A   = $clog2(MAX_ROWS + 1) + 1;
    localparam int RCMP_W = (RC_A > 11) ? RC_A : 11;

    pbr_pkg::pbr_phase_t phase_reg, phase_next;
    logic [7:0]          pend_reg, pend_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [PL_W-1:0]     plane_reg, plane_next;
    logic [RW_W-1:0]     row_reg, row_next;

    // geometry
    logic [8:0]        words;
    logic [9:0]        rb_raw;
    logic [SUM_W-1:0]  rb_floor, row_bytes;
    logic [3:0]        planes_eff;
    logic [RCMP_W-1:0] rows_floor, rows_eff;

    assign words      = 9'((13'(cfg.width) + pbr_pkg::WORD_ROUND) >> 4);
    assign rb_raw     = {words, 1'b0};
    assign rb_floor   = (rb_raw < 10'd2) ? SUM_W'(2) : SUM_W'(rb_raw);
    assign row_bytes  = (rb_floor > SUM_W'(MAX_ROW_BYTES)) ? SUM_W'(MAX_ROW_BYTES) : rb_floor;
    assign planes_eff = (cfg.planes == 4'd0) ? 4'd1 :
                        (cfg.planes > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : cfg.planes;
    assign rows_floor = (cfg.rows == 11'd0) ? RCMP_W'(1) : RCMP_W'(cfg.rows);
    assign rows_eff   = (rows_floor > RCMP_W'(MAX_ROWS)) ? RCMP_W'(MAX_ROWS) : rows_floor;

    // header classification
    logic       drop, hdr_nop, overrun;
    logic [8:0] cnt9;
    logic [7:0] count, pend_dec;

    assign drop     = (phase_reg == pbr_pkg::PH_DONE) || (phase_reg == pbr_pkg::PH_ERROR);
    assign hdr_nop  = (in_byte == pbr_pkg::HDR_NOP);
    assign cnt9     = in_byte[7] ? (9'd257 - {1'b0, in_byte}) : ({1'b0, in_byte} + 9'd1);
    assign count    = cnt9[7:0];
    assign overrun  = (SUM_W'(col_reg) + SUM_W'(count)) > row_bytes;
    assign pend_dec = (pend_reg == 8'd0) ? 8'd0 : pend_reg - 8'd1;

    // run and position datapath
    logic             valid, done, col_wrap, plane_wrap, row_wrap;
    logic [7:0]       length;
    logic [1:0]       status, status_out;
    logic [SUM_W-1:0] col_sum;
    logic [PL_W:0]    plane_inc;
    logic [RW_W:0]    row_inc;

    always_comb begin
        valid     = 1'b0;
        length    = 8'd1;
        status    = pbr_pkg::ST_OK;
        pend_next = pend_reg;
        if (!drop) begin
            if (!cfg.mode) begin
                valid     = 1'b1;
                pend_next = 8'd0;
            end else begin
                case (phase_reg)
                    pbr_pkg::PH_HEADER: begin
                        if (!hdr_nop) begin
                            if (overrun) begin
                                status = pbr_pkg::ST_OVERRUN;
                            end else begin
                                pend_next = count;
                            end
                        end
                    end
                    pbr_pkg::PH_LITERAL: begin
                        valid     = 1'b1;
                        pend_next = pend_dec;
                    end
                    pbr_pkg::PH_REPEAT: begin
                        valid     = 1'b1;
                        length    = (pend_reg == 8'd0) ? 8'd1 : pend_reg;
                        pend_next = 8'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end

        col_sum    = SUM_W'(col_reg) + SUM_W'(length);
        col_wrap   = col_sum >= row_bytes;
        plane_inc  = (PL_W + 1)'(plane_reg) + (PL_W + 1)'(1);
        plane_wrap = 5'(plane_inc) >= 5'(planes_eff);
        row_inc    = (RW_W + 1)'(row_reg) + (RW_W + 1)'(1);
        row_wrap   = RCMP_W'(row_inc) >= rows_eff;
        done       = valid && col_wrap && plane_wrap && row_wrap;

        col_next   = col_reg;
        plane_next = plane_reg;
        row_next   = row_reg;
        if (valid) begin
            col_next = col_wrap ? '0 : col_sum[COL_W-1:0];
            if (col_wrap) begin
                plane_next = plane_wrap ? '0 : plane_inc[PL_W-1:0];
                if (plane_wrap) begin
                    row_next = row_wrap ? '0 : row_inc[RW_W-1:0];
                end
            end
        end
        if (done) begin
            pend_next = 8'd0;
        end

        status_out = (in_last && !done && status == pbr_pkg::ST_OK) ?
                     pbr_pkg::ST_EARLY_END : status;
    end

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (in_last) begin
            phase_next = pbr_pkg::PH_HEADER;
        end else if (drop) begin
            phase_next = phase_reg;
        end else if (done) begin
            phase_next = pbr_pkg::PH_DONE;
        end else if (!cfg.mode) begin
            phase_next = pbr_pkg::PH_HEADER;
        end else begin
            case (phase_reg)
                pbr_pkg::PH_HEADER: begin
                    if (hdr_nop) begin
                        phase_next = pbr_pkg::PH_HEADER;
                    end else if (overrun) begin
                        phase_next = pbr_pkg::PH_ERROR;
                    end else if (in_byte[7]) begin
                        phase_next = pbr_pkg::PH_REPEAT;
                    end else begin
                        phase_next = pbr_pkg::PH_LITERAL;
                    end
                end
                pbr_pkg::PH_LITERAL: begin
                    phase_next = (pend_dec == 8'd0) ? pbr_pkg::PH_HEADER : pbr_pkg::PH_LITERAL;
                end
                pbr_pkg::PH_REPEAT: phase_next = pbr_pkg::PH_HEADER;
                default:            phase_next = pbr_pkg::PH_HEADER;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && in_last)) begin
            phase_reg <= pbr_pkg::PH_HEADER;
            pend_reg  <= 8'd0;
            col_reg   <= '0;
            plane_reg <= '0;
            row_reg   <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            col_reg   <= col_next;
            plane_reg <= plane_next;
            row_reg   <= row_next;
        end
    end

    // result word, positions masked to field widths
    logic [SUM_W-1:0]  col_ext;
    logic [4:0]        plane_ext;
    logic [RCMP_W-1:0] row_ext;

    assign col_ext   = SUM_W'(col_reg);
    assign plane_ext = 5'(plane_reg);
    assign row_ext   = RCMP_W'(row_reg);

    assign out_push              = in_fire && !drop && (valid || status_out != pbr_pkg::ST_OK);
    assign out_run.run_valid     = valid;
    assign out_run.run_value     = valid ? in_byte : 8'd0;
    assign out_run.run_length    = valid ? length : 8'd0;
    assign out_run.plane_index   = valid ? plane_ext[2:0] : 3'd0;
    assign out_run.row_index     = valid ? row_ext[9:0] : 10'd0;
    assign out_run.byte_offset   = valid ? col_ext[7:0] : 8'd0;
    assign out_run.decode_status = status_out;
    assign out_run.image_done    = done;

endmodule

// ----- rtl/pbr_queue.sv -----
// ----------------------------------------------------------------------------
// pbr_queue
// four-entry run word queue between front and back
// ----------------------------------------------------------------------------
module pbr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pbr_pkg::pbr_run_t din,
    output logic              full,
    input  logic              pop,
    output logic              nonempty,
    output pbr_pkg::pbr_run_t dout
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    pbr_pkg::pbr_run_t  slot_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               do_push, do_pop;

    assign full     = (count_reg == (AW + 1)'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign dout     = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (AW + 1)'(1);
                2'b01:   count_reg <= count_reg - (AW + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/pbr_back.sv -----
// ----------------------------------------------------------------------------
// pbr_back
// output stage: holds one run word and packs it onto the master stream
// ----------------------------------------------------------------------------
module pbr_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_nonempty,
    input  pbr_pkg::pbr_run_t            q_run,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pbr_pkg::TDATA_W-1:0]  m_tdata,
    output logic [pbr_pkg::TUSER_W-1:0]  m_tuser,
    output logic                         m_tlast
);

    logic              out_valid_reg;
    pbr_pkg::pbr_run_t out_run_reg;

    assign q_pop = q_nonempty && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= q_nonempty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_run_reg <= q_run;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0,
                       out_run_reg.byte_offset,
                       out_run_reg.row_index,
                       out_run_reg.plane_index,
                       out_run_reg.run_length,
                       out_run_reg.run_value};
    assign m_tuser  = {out_run_reg.decode_status, out_run_reg.run_valid};
    assign m_tlast  = out_run_reg.image_done;

endmodule

// ----- tb/planar_byterun1_decoder_test.sv -----
// ----------------------------------------------------------------------------
// planar_byterun1_decoder_test
// self-checking bench for the packbits / raw planar body decoder
// ----------------------------------------------------------------------------
// Body bytes go in on the s_ stream and run words come back on the m_ stream.
// A copy of the decoder state is kept next to the stream: every accepted byte
// is decoded again in the bench, and the word it should give is queued. Each
// run word leaving the block is checked field by field against the oldest
// queued word. A few short directed bodies come first, then random images,
// mostly well-formed with random content, some cut short, broken or noise.
// ----------------------------------------------------------------------------
module planar_byterun1_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_BYTES_MAX = 256;
    localparam int PLANES_MAX    = 8;
    localparam int ROWS_MAX      = 1024;
    localparam int RANDOM_ITEMS  = 500;
    localparam int BODY_CAP      = 400;   // size at which a random body stops adding rows
    localparam int DRAIN_CYCLES  = 8;     // settle time once no word is owed
    localparam int HOLD_CYCLES   = 64;    // long output hold-off
    localparam int PRINT_LIMIT   = 40;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration channel
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;

    // body byte stream
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // body_byte
    logic       s_tlast  = 1'b0; // body_last

    // run word stream
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    // run_value[7:0], run_length[15:8], plane_index[18:16],
    // row_index[28:19], byte_offset[36:29], zero pad[39:37]
    logic [pbr_pkg::TDATA_W-1:0]  m_tdata;
    // run_valid[0], decode_status[2:1]
    logic [pbr_pkg::TUSER_W-1:0]  m_tuser;
    logic                         m_tlast;  // image_done

    always #5 aclk = ~aclk;

    planar_byterun1_decoder #(
        .MAX_ROW_BYTES (ROW_BYTES_MAX),
        .MAX_PLANES    (PLANES_MAX),
        .MAX_ROWS      (ROWS_MAX)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // bench copy of the registers, at their reset values
    logic        cfg_mode   = 1'b1;
    logic [11:0] cfg_width  = 12'd320;
    logic [10:0] cfg_rows   = 11'd256;
    logic [3:0]  cfg_planes = 4'd5;

    // bench copy of the decoder position
    pbr_pkg::pbr_phase_t body_phase    = pbr_pkg::PH_HEADER;
    int                  pending_bytes = 0;
    int                  column_pos    = 0;
    int                  plane_pos     = 0;
    int                  row_pos       = 0;

    pbr_pkg::pbr_run_t expected_runs[$];   // words still owed by the block
    logic [7:0]        body_bytes[$];      // body being built for the sender

    int error_count  = 0;
    int random_items = 0;
    bit pace         = 1'b1;        // random gaps on both sides when set
    bit hold_output  = 1'b0;        // asks the receiver for a long hold-off
    bit hold_active  = 1'b0;

    // ------------------------------------------------------------------------
    // geometry as the decoder sees it
    // ------------------------------------------------------------------------
    function automatic int row_bytes();
        int rb;
        rb = ((int'(cfg_width) + int'(pbr_pkg::WORD_ROUND)) >> 4) << 1;
        if (rb < 2) rb = 2;
        if (rb > ROW_BYTES_MAX) rb = ROW_BYTES_MAX;
        return rb;
    endfunction

    function automatic int plane_limit();
        int p;
        p = int'(cfg_planes);
        if (p < 1) p = 1;
        if (p > PLANES_MAX) p = PLANES_MAX;
        return p;
    endfunction

    function automatic int row_limit();
        int r;
        r = int'(cfg_rows);
        if (r < 1) r = 1;
        if (r > ROWS_MAX) r = ROWS_MAX;
        return r;
    endfunction

    function automatic void restart_body();
        body_phase    = pbr_pkg::PH_HEADER;
        pending_bytes = 0;
        column_pos    = 0;
        plane_pos     = 0;
        row_pos       = 0;
    endfunction

    // ------------------------------------------------------------------------
    // decode one accepted byte and queue the word it gives, if any
    // ------------------------------------------------------------------------
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int                rb;
        int                remaining;
        int                count;
        int                length;
        bit                valid;
        bit                done;
        logic [1:0]        status;
        pbr_pkg::pbr_run_t word;
        valid  = 1'b0;
        done   = 1'b0;
        status = pbr_pkg::ST_OK;
        length = 0;
        word   = '0;

        // finished or failed image: drop until the last byte, which rearms
        if (body_phase == pbr_pkg::PH_DONE || body_phase == pbr_pkg::PH_ERROR) begin
            if (last) restart_body();
            return;
        end

        rb        = row_bytes();
        remaining = (column_pos < rb) ? rb - column_pos : 0;

        if (!cfg_mode) begin
            // raw rows: every phase acts as a plain copy
            body_phase    = pbr_pkg::PH_HEADER;
            pending_bytes = 0;
            valid         = 1'b1;
            length        = 1;
        end else if (body_phase == pbr_pkg::PH_HEADER) begin
            if (b != pbr_pkg::HDR_NOP) begin
                count = (b < 8'h80) ? int'(b) + 1 : 257 - int'(b);
                if (count > remaining) begin
                    status     = pbr_pkg::ST_OVERRUN;
                    body_phase = pbr_pkg::PH_ERROR;
                end else begin
                    pending_bytes = count;
                    body_phase    = (b < 8'h80) ? pbr_pkg::PH_LITERAL : pbr_pkg::PH_REPEAT;
                end
            end
        end else if (body_phase == pbr_pkg::PH_LITERAL) begin
            valid  = 1'b1;
            length = 1;
            if (pending_bytes > 0) pending_bytes--;
            if (pending_bytes == 0) body_phase = pbr_pkg::PH_HEADER;
        end else begin
            // repeat byte: one word carries the whole run
            valid         = 1'b1;
            length        = (pending_bytes == 0) ? 1 : pending_bytes;
            pending_bytes = 0;
            body_phase    = pbr_pkg::PH_HEADER;
        end

        if (valid) begin
            word.run_valid   = 1'b1;
            word.run_value   = b;
            word.run_length  = length[7:0];
            word.plane_index = plane_pos[2:0];
            word.row_index   = row_pos[9:0];
            word.byte_offset = column_pos[7:0];
            column_pos += length;
            if (column_pos >= rb) begin
                column_pos = 0;
                plane_pos++;
                if (plane_pos >= plane_limit()) begin
                    plane_pos = 0;
                    row_pos++;
                    if (row_pos >= row_limit()) begin
                        done          = 1'b1;
                        body_phase    = pbr_pkg::PH_DONE;
                        pending_bytes = 0;
                    end
                end
            end
        end

        if (last) begin
            if (!done && status == pbr_pkg::ST_OK) status = pbr_pkg::ST_EARLY_END;
            restart_body();
        end

        if (!valid && status == pbr_pkg::ST_OK) return;
        word.decode_status = status;
        word.image_done    = done;
        expected_runs.push_back(word);
    endfunction

    // ------------------------------------------------------------------------
    // pacing: mostly no gap, some short, a few long
    // ------------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        if (!pace) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [11:0] pick_one(input logic [11:0] a, b, c, d);
        case ($urandom_range(0, 3))
            0: return a;
            1: return b;
            2: return c;
            default: return d;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [9:0] got, want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        decode_byte(b, last);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and wait until every owed word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_runs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (index)
            pbr_pkg::REG_COMPRESSION_MODE: cfg_mode   = data[0];
            pbr_pkg::REG_IMAGE_WIDTH:      cfg_width  = data;
            pbr_pkg::REG_IMAGE_ROWS:       cfg_rows   = data[10:0];
            pbr_pkg::REG_PLANE_COUNT:      cfg_planes = data[3:0];
            default: ;
        endcase
    endtask

    // all four registers, only once the block has gone quiet
    task automatic write_geometry(input logic mode, input logic [11:0] width, rows, planes);
        wait_drained();
        write_register(pbr_pkg::REG_COMPRESSION_MODE, {11'd0, mode});
        write_register(pbr_pkg::REG_IMAGE_WIDTH, width);
        write_register(pbr_pkg::REG_IMAGE_ROWS, rows);
        write_register(pbr_pkg::REG_PLANE_COUNT, planes);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // well-formed body for the current geometry, stopping once the cap is reached
    task automatic build_image_bytes(input int cap);
        int plane_rows;
        int left;
        int lim;
        int n;
        int pick;
        body_bytes.delete();
        plane_rows = row_limit() * plane_limit();
        for (int pr = 0; pr < plane_rows && body_bytes.size() < cap; pr++) begin
            left = row_bytes();
            while (left > 0) begin
                lim  = (left < 128) ? left : 128;
                n    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, lim)
                                                   : $urandom_range(1, (lim < 4) ? lim : 4);
                pick = $urandom_range(0, 19);
                if (!cfg_mode) begin
                    body_bytes.push_back(8'($urandom_range(0, 255)));
                    left--;
                end else if (pick < 2) begin
                    body_bytes.push_back(pbr_pkg::HDR_NOP);
                end else if (pick < 11 || n < 2) begin
                    // literal run of n bytes
                    body_bytes.push_back(8'(n - 1));
                    repeat (n) body_bytes.push_back(8'($urandom_range(0, 255)));
                    left -= n;
                end else begin
                    // repeat run of n copies
                    body_bytes.push_back(8'(257 - n));
                    body_bytes.push_back(8'($urandom_range(0, 255)));
                    left -= n;
                end
            end
        end
    endtask

    task automatic trim_body(input int keep);
        while (body_bytes.size() > keep) void'(body_bytes.pop_back());
    endtask

    task automatic send_body();
        bit live;
        for (int i = 0; i < body_bytes.size(); i++) begin
            // dropped bytes do not count as real stimulus
            live = !(body_phase == pbr_pkg::PH_DONE || body_phase == pbr_pkg::PH_ERROR);
            send_byte(body_bytes[i], i == body_bytes.size() - 1);
            if (live) random_items++;
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random ready, with a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : output_pacer
        int stall;
        int held;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_output) begin
                hold_active = 1'b1;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
                hold_output = 1'b0;
                hold_active = 1'b0;
            end else begin
                stall = gap_len();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // word checker: oldest owed word against each accepted word
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : run_checker
        pbr_pkg::pbr_run_t got;
        pbr_pkg::pbr_run_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.run_valid     = m_tuser[0];
            got.decode_status = m_tuser[2:1];
            got.run_value     = m_tdata[7:0];
            got.run_length    = m_tdata[15:8];
            got.plane_index   = m_tdata[18:16];
            got.row_index     = m_tdata[28:19];
            got.byte_offset   = m_tdata[36:29];
            got.image_done    = m_tlast;
            if (expected_runs.size() == 0) begin
                report_mismatch($sformatf("run word %h/%h with none owed", m_tdata, m_tuser));
            end else begin
                want = expected_runs.pop_front();
                check_field("run_valid", 10'(got.run_valid), 10'(want.run_valid));
                check_field("run_value", 10'(got.run_value), 10'(want.run_value));
                check_field("run_length", 10'(got.run_length), 10'(want.run_length));
                check_field("plane_index", 10'(got.plane_index), 10'(want.plane_index));
                check_field("row_index", got.row_index, want.row_index);
                check_field("byte_offset", 10'(got.byte_offset), 10'(want.byte_offset));
                check_field("decode_status", 10'(got.decode_status),
                            10'(want.decode_status));
                check_field("image_done", 10'(got.image_done), 10'(want.image_done));
            end
        end
    end

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // reset geometry: literal, repeat, no-op, then a last header ends early
    task automatic test_reset_defaults();
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(pbr_pkg::HDR_NOP, 1'b0);
        send_byte(pbr_pkg::HDR_NOP, 1'b1);
    endtask

    // widest rows: two 128-long repeats fill a plane row, last byte mid-literal
    task automatic test_packbits_extremes();
        write_geometry(1'b1, 12'd2048, 12'd1024, 12'd8);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    // run past the row end, on a last byte and then mid-body with dropping
    task automatic test_row_overrun();
        write_geometry(1'b1, 12'd16, 12'd3, 12'd2);
        send_byte(8'h02, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // raw copy completes a tiny image, then trailing bytes are dropped
    task automatic test_raw_image_done();
        write_geometry(1'b0, 12'd1, 12'd1, 12'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
    endtask

    // geometry and mode change in the middle of a literal run; zero
    // geometry values and over-range counts are clamped, the position wraps
    task automatic test_config_mid_image();
        write_geometry(1'b1, 12'd64, 12'd2047, 12'd15);
        send_byte(8'h03, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        write_geometry(1'b0, 12'd0, 12'd0, 12'd0);
        send_byte(8'h99, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // receiver holds off while bytes keep coming, then a pause mid-image
    task automatic test_backpressure();
        write_geometry(1'b0, 12'd64, 12'd2, 12'd2);
        pace = 1'b0;
        build_image_bytes(BODY_CAP);
        hold_output = 1'b1;
        wait (hold_active);
        for (int i = 0; i < 24; i++) send_byte(body_bytes[i], 1'b0);
        wait_drained();
        for (int i = 24; i < body_bytes.size(); i++)
            send_byte(body_bytes[i], i == body_bytes.size() - 1);
        pace = 1'b1;
    endtask

    // random images: mostly well-formed, some cut, broken, noisy or padded
    task automatic test_random_bodies();
        int kind;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                write_geometry(1'($urandom_range(0, 1)),
                               pick_one(12'd0, 12'd1, 12'd2048, 12'd4095),
                               pick_one(12'd0, 12'd1, 12'd1024, 12'd2047),
                               pick_one(12'd0, 12'd1, 12'd8, 12'd15));
            else
                write_geometry($urandom_range(0, 3) != 0, 12'($urandom_range(1, 64)),
                               12'($urandom_range(1, 4)), 12'($urandom_range(1, 3)));
            pace = ($urandom_range(0, 3) != 0);
            build_image_bytes(BODY_CAP);
            kind = $urandom_range(0, 9);
            case (kind)
                5: begin
                    // cut short
                    trim_body($urandom_range(1, body_bytes.size() - 1));
                end
                6: begin
                    // oversized header dropped in, then junk
                    trim_body($urandom_range(0, body_bytes.size() - 1));
                    body_bytes.push_back(8'h7F);
                    repeat ($urandom_range(1, 5)) body_bytes.push_back(8'($urandom_range(0, 255)));
                end
                7: begin
                    // pure noise
                    body_bytes.delete();
                    repeat ($urandom_range(1, 40)) body_bytes.push_back(8'($urandom_range(0, 255)));
                end
                8: begin
                    // junk after a complete image
                    repeat ($urandom_range(1, 6)) body_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            send_body();
        end
        pace = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int settle;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_packbits_extremes();
        test_row_overrun();
        test_raw_image_done();
        test_config_mid_image();
        test_backpressure();
        test_random_bodies();

        // let the last words out, then a little longer
        s_tvalid <= 1'b0;
        for (settle = 0; settle < 4000 && expected_runs.size() != 0; settle++)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (expected_runs.size() != 0)
            report_mismatch($sformatf("%0d run words never came", expected_runs.size()));

        if (error_count == 0) begin
            $display("planar_byterun1_decoder_test: PASS");
        end else begin
            $display("planar_byterun1_decoder_test: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin : run_limit
        #5_000_000;
        $display("planar_byterun1_decoder_test: FAIL");
        $finish;
    end

endmodule
